// ===== rtl/tpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Tag player sleep controller package
// Widths, codes and constants shared by the interfaces and the controller.
// ----------------------------------------------------------------------------
package tpsc_pkg;

    localparam int NOW_MS_W    = 32;
    localparam int KNOB_W      = 2;
    localparam int ACTION_W    = 3;
    localparam int IDLE_MIN_W  = 8;
    localparam int MISS_CNT_W  = 4;
    localparam int THRESH_W    = 24;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

    localparam logic [KNOB_W-1:0] KNOB_NONE      = 2'd0;
    localparam logic [KNOB_W-1:0] KNOB_LONG_HOLD = 2'd2;

    localparam logic REG_IDLE_SLEEP_MINUTES = 1'b0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WAKE    = 3'd0,
        ACT_MENU    = 3'd1,
        ACT_PLAY    = 3'd2,
        ACT_REMOVED = 3'd3,
        ACT_SLEEP   = 3'd4
    } t_action;

endpackage

// ===== rtl/tpsc_if.sv =====
// ----------------------------------------------------------------------------
// Tag player sleep controller channels
// Valid/ready channels for tick requests and action results.
// ----------------------------------------------------------------------------
interface tpsc_tick_if
    import tpsc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [NOW_MS_W-1:0] now_ms;
    logic [KNOB_W-1:0]   knob_event;
    logic                tag_seen;
    logic                sleep_timer_fired;
    logic                audio_active;

    modport source (
        output valid, now_ms, knob_event, tag_seen, sleep_timer_fired, audio_active,
        input  ready
    );
    modport sink (
        input  valid, now_ms, knob_event, tag_seen, sleep_timer_fired, audio_active,
        output ready
    );
endinterface

interface tpsc_action_if
    import tpsc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action_code;

    modport source (
        output valid, action_code,
        input  ready
    );
    modport sink (
        input  valid, action_code,
        output ready
    );
endinterface

// ===== rtl/tag_player_sleep_controller.sv =====
// ----------------------------------------------------------------------------
// Tag player sleep controller
// Tracks sleep/awake mode, tag presence and idle time, at most one action per tick.
// ----------------------------------------------------------------------------
// The block accepts one tick request every clock cycle unless a result that
// is not yet taken stalls it. Each request passes an input register and then
// a result register, which offers its action; ticks that cause no action produce
// no result. The idle threshold is multiplied out when the register is
// written, so the per-tick path is one 32-bit subtract and compare.
module tag_player_sleep_controller
    import tpsc_pkg::*;
#(
    parameter int unsigned MISS_CONFIRM_TICKS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tpsc_tick_if.sink             i_tick,
    tpsc_action_if.source         o_action,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [MISS_CNT_W-1:0] MissLimit = MISS_CNT_W'(MISS_CONFIRM_TICKS);

    logic [IDLE_MIN_W-1:0] r_idle_minutes;
    logic [THRESH_W-1:0]   r_sleep_thresh;

    logic                  r_in_valid;
    logic [NOW_MS_W-1:0]   r_now_ms;
    logic [KNOB_W-1:0]     r_knob;
    logic                  r_seen;
    logic                  r_fired;
    logic                  r_audio;

    logic                  r_asleep;
    logic                  r_tag_on;
    logic                  r_suppressed;
    logic [MISS_CNT_W-1:0] r_miss;
    logic [NOW_MS_W-1:0]   r_last_ms;

    logic                  r_out_valid;
    t_action               r_out_action;

    logic                  n_asleep;
    logic                  n_tag_on;
    logic                  n_suppressed;
    logic [MISS_CNT_W-1:0] n_miss;
    logic [NOW_MS_W-1:0]   n_last_ms;
    logic                  n_has_result;
    t_action               n_action;

    logic                  w_fire;
    logic                  w_cfg_write;
    logic [THRESH_W-1:0]   w_thresh;
    logic [NOW_MS_W-1:0]   w_idle_ms;
    logic [MISS_CNT_W-1:0] w_miss_inc;

    assign w_fire      = r_in_valid && (!r_out_valid || o_action.ready);
    assign i_tick.ready = !r_in_valid || w_fire;

    assign o_action.valid       = r_out_valid;
    assign o_action.action_code = r_out_action;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && (paddr[2] == REG_IDLE_SLEEP_MINUTES);
    assign w_thresh    = THRESH_W'(pwdata[IDLE_MIN_W-1:0]) * THRESH_W'(MS_PER_MINUTE);
    assign prdata      = (paddr[2] == REG_IDLE_SLEEP_MINUTES)
                       ? APB_DATA_W'(r_idle_minutes) : '0;

    assign w_miss_inc  = r_miss + 1'b1;

    always_comb begin
        n_asleep     = r_asleep;
        n_tag_on     = r_tag_on;
        n_suppressed = r_suppressed;
        n_miss       = r_miss;
        n_last_ms    = r_last_ms;
        n_has_result = 1'b0;
        n_action     = ACT_WAKE;
        w_idle_ms    = '0;

        if (r_knob != KNOB_NONE) begin
            n_last_ms = r_now_ms;
        end

        if (r_asleep) begin
            if ((r_knob != KNOB_NONE) || (r_seen && !r_suppressed)) begin
                n_asleep     = 1'b0;
                n_last_ms    = r_now_ms;
                n_has_result = 1'b1;
                n_action     = ACT_WAKE;
            end
        end else begin
            if (r_fired) begin
                n_suppressed = 1'b1;
                n_last_ms    = r_now_ms;
            end

            if (r_knob == KNOB_LONG_HOLD) begin
                n_has_result = 1'b1;
                n_action     = ACT_MENU;
            end else begin
                if (r_seen) begin
                    if (r_tag_on) begin
                        n_miss = '0;
                    end else if (!n_suppressed) begin
                        n_tag_on     = 1'b1;
                        n_miss       = '0;
                        n_last_ms    = r_now_ms;
                        n_has_result = 1'b1;
                        n_action     = ACT_PLAY;
                    end
                end else if (r_tag_on) begin
                    n_miss = w_miss_inc;
                    if (w_miss_inc >= MissLimit) begin
                        n_tag_on     = 1'b0;
                        n_suppressed = 1'b0;
                        n_miss       = '0;
                        n_last_ms    = r_now_ms;
                        n_has_result = 1'b1;
                        n_action     = ACT_REMOVED;
                    end
                end

                w_idle_ms = r_now_ms - n_last_ms;
                if (!n_has_result && !r_audio && (!n_tag_on || n_suppressed)
                        && (r_sleep_thresh != '0)
                        && (w_idle_ms >= NOW_MS_W'(r_sleep_thresh))) begin
                    n_asleep     = 1'b1;
                    n_has_result = 1'b1;
                    n_action     = ACT_SLEEP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_minutes <= '0;
            r_sleep_thresh <= '0;
            r_in_valid     <= 1'b0;
            r_asleep       <= 1'b0;
            r_tag_on       <= 1'b0;
            r_suppressed   <= 1'b0;
            r_miss         <= '0;
            r_last_ms      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_cfg_write) begin
                r_idle_minutes <= pwdata[IDLE_MIN_W-1:0];
                r_sleep_thresh <= w_thresh;
            end

            if (i_tick.ready) begin
                r_in_valid <= i_tick.valid;
            end

            if (w_fire) begin
                r_asleep     <= n_asleep;
                r_tag_on     <= n_tag_on;
                r_suppressed <= n_suppressed;
                r_miss       <= n_miss;
                r_last_ms    <= n_last_ms;
                r_out_valid  <= n_has_result;
            end else if (o_action.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.ready && i_tick.valid) begin
            r_now_ms <= i_tick.now_ms;
            r_knob   <= i_tick.knob_event;
            r_seen   <= i_tick.tag_seen;
            r_fired  <= i_tick.sleep_timer_fired;
            r_audio  <= i_tick.audio_active;
        end
        if (w_fire && n_has_result) begin
            r_out_action <= n_action;
        end
    end

endmodule
